>>> hw/rtl/text_console_char_writer_macros.svh
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// Check that a condition holds at every edge outside reset.
`define TCCW_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define TCCW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_BLANK     = 8'h20;
  localparam logic [7:0] ATTR_RESET     = 8'h07;

  localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CHAR_BLANK};

  localparam logic CFG_TEXT_ATTR = 1'b0;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_RDWAIT = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_BLANK  = 6'b010000,
    ST_HOLD   = 6'b100000
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/text_console_char_writer.sv
// Throughput: one request at a time; the single write port of the screen
//   memory sets the sweep rate of one cell per cycle for scroll and clear.
// Reset: cursor homes, attribute 0x07, then a clearing pass writes 0x0720
//   to every cell while requests stall; register writes go on.
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_char_writer_macros.svh"

module text_console_char_writer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [10:0] cell_addr_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       cursor_row_o,
  output logic [6:0]       cursor_col_o,
  output logic [10:0]      cursor_pos_o,
  output logic [15:0]      cell_data_o,
  output logic             scrolled_o
);

  localparam int AW = tccw_pkg::ADDR_W;
  localparam int RW = tccw_pkg::ROW_W;
  localparam int CW = tccw_pkg::COL_W;
  localparam int DW = tccw_pkg::CELL_W;

  tccw_pkg::state_e st_q, st_d;

  logic [AW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [7:0]    attr_q;
  logic [DW-1:0] cell_q, cell_d;
  logic          scrl_q, scrl_d;
  logic          copy_pend_q, copy_pend_d;
  logic [AW-1:0] copy_addr_q, copy_addr_d;

  logic          out_valid_q, out_valid_d;
  logic [4:0]    out_row_q, out_row_d;
  logic [6:0]    out_col_q, out_col_d;
  logic [10:0]   out_pos_q, out_pos_d;
  logic [15:0]   out_data_q, out_data_d;
  logic          out_scrl_q, out_scrl_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic          in_accept;
  logic          cfg_we;
  logic [AW-1:0] cur_pos;
  logic [DW-1:0] blank;
  logic          row_last;
  logic          col_last;
  logic          addr_ok;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == tccw_pkg::CFG_TEXT_ATTR) ? {24'b0, attr_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccw_pkg::ATTR_RESET;
    end else if (cfg_we && paddr[2] == tccw_pkg::CFG_TEXT_ATTR) begin
      attr_q <= pwdata[7:0];
    end
  end

  assign in_stall_o = (st_q != tccw_pkg::ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign cur_pos  = AW'(AW'(row_q) * AW'(tccw_pkg::COLUMNS) + AW'(col_q));
  assign blank    = {attr_q, tccw_pkg::CHAR_BLANK};
  assign row_last = (row_q == RW'(tccw_pkg::ROWS - 1));
  assign col_last = (col_q == CW'(tccw_pkg::COLUMNS - 1));
  assign addr_ok  = (32'(cell_addr_i) < 32'(tccw_pkg::CELLS));

  tccw_ram #(
    .WIDTH (DW),
    .DEPTH (tccw_pkg::CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    cell_d      = cell_q;
    scrl_d      = scrl_q;
    copy_pend_d = 1'b0;
    copy_addr_d = copy_addr_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_pos;
    ram_wdata   = blank;
    ram_raddr   = AW'(cnt_q + AW'(tccw_pkg::COLUMNS));
    out_valid_d = out_valid_q & out_stall_i;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_pos_d   = out_pos_q;
    out_data_d  = out_data_q;
    out_scrl_d  = out_scrl_q;

    case (st_q)
      tccw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = tccw_pkg::RESET_BLANK;
        if (cnt_q == AW'(tccw_pkg::CELLS - 1)) begin
          cnt_d = '0;
          st_d  = tccw_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (in_accept) begin
          cell_d = '0;
          scrl_d = 1'b0;
          st_d   = tccw_pkg::ST_HOLD;
          case (req_type_i)
            tccw_pkg::REQ_PUT: begin
              if (char_code_i == tccw_pkg::CHAR_BACKSPACE) begin
                if (cur_pos != '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = cur_pos - 1'b1;
                  if (col_q != '0) begin
                    col_d = col_q - 1'b1;
                  end else begin
                    row_d = row_q - 1'b1;
                    col_d = CW'(tccw_pkg::COLUMNS - 1);
                  end
                end
              end else begin
                if (char_code_i != tccw_pkg::CHAR_NEWLINE) begin
                  ram_we    = 1'b1;
                  ram_wdata = {attr_q, char_code_i};
                end
                if (char_code_i == tccw_pkg::CHAR_NEWLINE || col_last) begin
                  col_d = '0;
                  if (row_last) begin
                    scrl_d = 1'b1;
                    cnt_d  = '0;
                    st_d   = tccw_pkg::ST_SCROLL;
                  end else begin
                    row_d = row_q + 1'b1;
                  end
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            end
            tccw_pkg::REQ_CLEAR: begin
              row_d = '0;
              col_d = '0;
              cnt_d = '0;
              st_d  = tccw_pkg::ST_BLANK;
            end
            tccw_pkg::REQ_READ: begin
              if (addr_ok) begin
                ram_raddr = AW'(cell_addr_i);
                st_d      = tccw_pkg::ST_RDWAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tccw_pkg::ST_RDWAIT: begin
        cell_d = ram_rdata;
        st_d   = tccw_pkg::ST_HOLD;
      end
      tccw_pkg::ST_SCROLL: begin
        if (copy_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = copy_addr_q;
          ram_wdata = ram_rdata;
        end
        if (cnt_q != AW'(tccw_pkg::MOVE_CELLS)) begin
          copy_pend_d = 1'b1;
          copy_addr_d = cnt_q;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          st_d = tccw_pkg::ST_BLANK;
        end
      end
      tccw_pkg::ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        if (cnt_q == AW'(tccw_pkg::CELLS - 1)) begin
          cnt_d = '0;
          st_d  = tccw_pkg::ST_HOLD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tccw_pkg::ST_HOLD: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_row_d   = 5'(row_q);
          out_col_d   = 7'(col_q);
          out_pos_d   = 11'(cur_pos);
          out_data_d  = cell_q;
          out_scrl_d  = scrl_q;
          st_d        = tccw_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = tccw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= tccw_pkg::ST_INIT;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      scrl_q      <= 1'b0;
      copy_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      scrl_q      <= scrl_d;
      copy_pend_q <= copy_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q      <= cell_d;
    copy_addr_q <= copy_addr_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_pos_q   <= out_pos_d;
    out_data_q  <= out_data_d;
    out_scrl_q  <= out_scrl_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cursor_pos_o = out_pos_q;
  assign cell_data_o  = out_data_q;
  assign scrolled_o   = out_scrl_q;

  `TCCW_ASSERT(a_cursor_in_screen, clk_i, rst_ni,
    (32'(row_q) < tccw_pkg::ROWS) && (32'(col_q) < tccw_pkg::COLUMNS),
    "cursor left the screen")
  `TCCW_ASSERT_IMPL(a_scroll_on_last_row, clk_i, rst_ni,
    (st_q == tccw_pkg::ST_HOLD) && scrl_q, row_last && (col_q == '0),
    "scroll reported off the last row")
  `TCCW_ASSERT_IMPL(a_copy_only_in_scroll, clk_i, rst_ni,
    copy_pend_q, st_q == tccw_pkg::ST_SCROLL,
    "pending copy outside the scroll sweep")

endmodule

`default_nettype wire

>>> hw/rtl/tccw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
